// ----- rtl/ip_fragment_reassembly_tracker_assert.svh -----
// Assertion macros for the fragment reassembly tracker.
`ifndef IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define IFRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define IFRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ifrt_pkg.sv -----
// Shared types and constants of the fragment reassembly tracker.
package ifrt_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int MAX_BLOCKS_DEF = 8192;
    localparam logic [7:0] EXPIRE_RESET = 8'd30;

    localparam int KEY_W = 88;
    localparam int OFF_W = 13;
    localparam int LEN_W = 16;
    localparam int BLK_W = 14;

    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_FULL      = 3'd2,
        ST_TICK      = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    time_inc;
        logic    idx_clr;
        logic    idx_inc;
        logic    rec_hit;
        logic    rec_free;
        logic    alloc;
        logic    w_clr;
        logic    w_first;
        logic    w_inc;
        logic    bm_zero_wr;
        logic    bm_mark_wr;
        logic    len_wr;
        logic    len_latch;
        logic    slot_free;
        logic    tick_check;
        logic    kind_set;
        status_t kind;
        logic    res_load;
    } ifrt_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic malformed;
        logic idx_last;
        logic match;
        logic free_found;
        logic clr_last;
        logic nblk_zero;
        logic mk_last;
        logic is_last;
        logic known;
        logic cnt_zero;
        logic ck_ok;
        logic ck_last;
        logic out_busy;
    } ifrt_sts_t;

endpackage

// ----- rtl/ip_fragment_reassembly_tracker.sv -----
// IP fragment reassembly tracker: top level with stream ports and checks.
// Usage: fragment and tick beats enter on the s_ channel (s_tuser = 0
// fragment, 1 tick); each beat yields exactly one result beat on the m_
// channel, m_tuser carrying the status code. cfg_wr_en/cfg_wr_data write
// the slot lifetime in ticks while the block is idle.
// One item is worked on at a time; s_tready is high only while idle.
// A tick advances time and checks every slot for expiry. A fragment is first
// checked for being malformed, then looked up slot by slot (stops at the hit,
// all ENTRIES on a miss); a miss with no free slot is dropped as table-full.
// On allocation the new slot's bitmap row is wiped word by word; then the
// bitmap words covered are marked, the length is stored for a last fragment
// and read back, and the words up to that length are checked for completion.
// The bitmap memory is single-port (read then write per word) and the slot
// table gives one read per cycle; WORDS = MAX_BLOCKS/64 rounded up.
// Reset empties the table, zeroes time and sets the lifetime to 30.
// The result register holds a beat while m_tready is low; the next item is
// taken meanwhile and its work waits only when it would overwrite that beat.
module ip_fragment_reassembly_tracker import ifrt_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source address, destination address, protocol, ident, fragment offset,
    // more_fragments, payload_len, zero pad
    input  logic [119:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot, capture_header, write_offset, data_len, expired_count
    output logic [39:0]  m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    `include "ip_fragment_reassembly_tracker_assert.svh"

    ifrt_cmd_t   cmd;
    ifrt_sts_t   sts;
    logic [2:0]  o_slot;
    logic        o_cap;
    logic [15:0] o_wo;
    logic [15:0] o_dl;
    logic [3:0]  o_ec;

    ifrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ifrt_datapath #(
        .ENTRIES    (ENTRIES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_operation       (s_tuser),
        .in_src_ip          (s_tdata[31:0]),
        .in_dst_ip          (s_tdata[63:32]),
        .in_protocol        (s_tdata[71:64]),
        .in_ident           (s_tdata[87:72]),
        .in_frag_off        (s_tdata[100:88]),
        .in_more_fragments  (s_tdata[101]),
        .in_payload_len     (s_tdata[117:102]),
        .cmd                (cmd),
        .sts                (sts),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_slot           (o_slot),
        .out_status         (m_tuser),
        .out_capture_header (o_cap),
        .out_write_offset   (o_wo),
        .out_data_len       (o_dl),
        .out_expired_count  (o_ec)
    );

    assign m_tdata = {o_ec, o_dl, o_wo, o_cap, o_slot};

    `IFRT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted while an item is still in work")
    `IFRT_ASSERT_IMP(a_drop_clean,
        m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_MALFORMED),
        m_tdata == 40'd0, "dropped fragment carries non-zero result fields")
    `IFRT_ASSERT_IMP(a_tick_clean, m_tvalid && m_tuser == ST_TICK,
        m_tdata[35:0] == 36'd0, "tick result carries fragment fields")

endmodule

// ----- rtl/ifrt_datapath.sv -----
// Datapath: slot table, block bitmap memory, time base and result register.
module ifrt_datapath import ifrt_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              in_operation,
    input  logic [31:0]       in_src_ip,
    input  logic [31:0]       in_dst_ip,
    input  logic [7:0]        in_protocol,
    input  logic [15:0]       in_ident,
    input  logic [OFF_W-1:0]  in_frag_off,
    input  logic              in_more_fragments,
    input  logic [LEN_W-1:0]  in_payload_len,
    input  ifrt_cmd_t         cmd,
    output ifrt_sts_t         sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [2:0]        out_slot,
    output logic [2:0]        out_status,
    output logic              out_capture_header,
    output logic [15:0]       out_write_offset,
    output logic [15:0]       out_data_len,
    output logic [3:0]        out_expired_count
);

    localparam int WORDS  = (MAX_BLOCKS + 63) / 64;
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BM_D   = ENTRIES * WORDS;
    localparam int BM_AW  = (BM_D > 1) ? $clog2(BM_D) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    function automatic logic [63:0] range_mask(input logic [BLK_W-1:0] base,
                                               input logic [BLK_W-1:0] lo,
                                               input logic [BLK_W-1:0] hi);
        logic [63:0]      m;
        logic [BLK_W-1:0] b;
        for (int i = 0; i < 64; i++) begin
            b    = base + BLK_W'(i);
            m[i] = (b >= lo) && (b < hi);
        end
        return m;
    endfunction

    logic [7:0]          expire_ticks_reg;
    logic [31:0]         time_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [ENTRIES-1:0]  known_reg, known_next;
    logic                out_valid_reg;

    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                mf_reg;
    logic [LEN_W-1:0]    plen_reg;

    logic [SLOT_W-1:0]   idx_reg, slot_reg, free_idx_reg;
    logic                free_found_reg;
    logic [WORD_W-1:0]   w_reg;
    logic [LEN_W-1:0]    chk_len_reg;
    logic [CNT_W-1:0]    freed_reg;
    status_t             kind_reg;

    logic [2:0]          o_slot_reg, o_status_reg;
    logic                o_cap_reg;
    logic [15:0]         o_wo_reg, o_dl_reg;
    logic [3:0]          o_ec_reg;

    logic [KEY_W-1:0]    key_mem [ENTRIES];
    logic [31:0]         exp_mem [ENTRIES];
    logic [LEN_W-1:0]    len_mem [ENTRIES];
    logic [63:0]         bm_mem  [BM_D];
    logic [KEY_W-1:0]    key_q;
    logic [31:0]         exp_q;
    logic [LEN_W-1:0]    len_q;
    logic [63:0]         bm_q;

    logic [16:0]         end_w, plen_rnd, len_rnd;
    logic [BLK_W-1:0]    nblk, blk_hi, cnt_raw, cnt, w_base;
    logic [WORD_W-1:0]   first_w, mk_last_w, ck_last_w;
    logic [BM_AW-1:0]    bm_addr;
    logic [63:0]         mark_mask, need_mask;
    logic [31:0]         diff;
    logic                expired, frag_ok;
    logic [SLOT_W+2:0]   slot_ext;
    logic [CNT_W+3:0]    freed_ext;

    always_comb begin
        end_w     = {1'b0, off_reg, 3'b000} + {1'b0, plen_reg};
        plen_rnd  = {1'b0, plen_reg} + 17'd7;
        nblk      = plen_rnd[16:3];
        blk_hi    = {1'b0, off_reg} + nblk;
        len_rnd   = {1'b0, chk_len_reg} + 17'd7;
        cnt_raw   = len_rnd[16:3];
        cnt       = (cnt_raw > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : cnt_raw;
        first_w   = WORD_W'(off_reg >> 6);
        mk_last_w = WORD_W'((blk_hi - BLK_W'(1)) >> 6);
        ck_last_w = WORD_W'((cnt - BLK_W'(1)) >> 6);
        w_base    = BLK_W'(w_reg) << 6;
        mark_mask = range_mask(w_base, {1'b0, off_reg}, blk_hi);
        need_mask = range_mask(w_base, '0, cnt);
        bm_addr   = BM_AW'(slot_reg) * BM_AW'(WORDS) + BM_AW'(w_reg);
        diff      = exp_q - time_reg;
        expired   = valid_reg[idx_reg] && ((diff == 32'd0) || diff[31]);
        slot_ext  = {3'b000, slot_reg};
        freed_ext = {4'b0000, freed_reg};
        frag_ok   = (kind_reg == ST_PENDING) || (kind_reg == ST_COMPLETE);
    end

    always_comb begin
        sts.is_tick    = op_reg;
        sts.malformed  = end_w[16] || (blk_hi > BLK_W'(MAX_BLOCKS));
        sts.idx_last   = idx_reg == SLOT_W'(ENTRIES - 1);
        sts.match      = valid_reg[idx_reg] && (key_q == key_reg);
        sts.free_found = free_found_reg || !valid_reg[idx_reg];
        sts.clr_last   = w_reg == WORD_W'(WORDS - 1);
        sts.nblk_zero  = nblk == '0;
        sts.mk_last    = w_reg == mk_last_w;
        sts.is_last    = !mf_reg;
        sts.known      = known_reg[slot_reg];
        sts.cnt_zero   = cnt == '0;
        sts.ck_ok      = (bm_q & need_mask) == need_mask;
        sts.ck_last    = w_reg == ck_last_w;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb begin
        valid_next = valid_reg;
        known_next = known_reg;
        if (cmd.alloc) begin
            valid_next[free_idx_reg] = 1'b1;
            known_next[free_idx_reg] = 1'b0;
        end
        if (cmd.len_wr) begin
            known_next[slot_reg] = 1'b1;
        end
        if (cmd.slot_free) begin
            valid_next[slot_reg] = 1'b0;
            known_next[slot_reg] = 1'b0;
        end
        if (cmd.tick_check && expired) begin
            valid_next[idx_reg] = 1'b0;
            known_next[idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expire_ticks_reg <= EXPIRE_RESET;
            time_reg         <= '0;
            valid_reg        <= '0;
            known_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                expire_ticks_reg <= cfg_wr_data;
            end
            if (cmd.time_inc) begin
                time_reg <= time_reg + 32'd1;
            end
            valid_reg <= valid_next;
            known_reg <= known_next;
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_operation;
            key_reg  <= {in_src_ip, in_dst_ip, in_protocol, in_ident};
            off_reg  <= in_frag_off;
            mf_reg   <= in_more_fragments;
            plen_reg <= in_payload_len;
        end
        if (cmd.idx_clr) begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            freed_reg      <= '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.rec_free && !free_found_reg && !valid_reg[idx_reg]) begin
                free_idx_reg   <= idx_reg;
                free_found_reg <= 1'b1;
            end
            if (cmd.tick_check && expired) begin
                freed_reg <= freed_reg + CNT_W'(1);
            end
        end
        if (cmd.rec_hit) begin
            slot_reg <= idx_reg;
        end else if (cmd.alloc) begin
            slot_reg <= free_idx_reg;
        end
        if (cmd.w_clr) begin
            w_reg <= '0;
        end else if (cmd.w_first) begin
            w_reg <= first_w;
        end else if (cmd.w_inc) begin
            w_reg <= w_reg + WORD_W'(1);
        end
        if (cmd.len_latch) begin
            chk_len_reg <= mf_reg ? len_q : end_w[15:0];
        end
        if (cmd.kind_set) begin
            kind_reg <= cmd.kind;
        end
        if (cmd.res_load) begin
            o_status_reg <= kind_reg;
            o_slot_reg   <= frag_ok ? slot_ext[2:0] : 3'd0;
            o_cap_reg    <= frag_ok && (off_reg == '0);
            o_wo_reg     <= frag_ok ? {off_reg, 3'b000} : 16'd0;
            o_dl_reg     <= (kind_reg == ST_COMPLETE) ? chk_len_reg : 16'd0;
            o_ec_reg     <= (kind_reg == ST_TICK) ? freed_ext[3:0] : 4'd0;
        end
    end

    // Slot table memories: one write port, one registered read port each.
    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            key_mem[free_idx_reg] <= key_reg;
            exp_mem[free_idx_reg] <= time_reg + {24'd0, expire_ticks_reg};
        end
        key_q <= key_mem[idx_reg];
        exp_q <= exp_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.len_wr) begin
            len_mem[slot_reg] <= end_w[15:0];
        end
        len_q <= len_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.bm_zero_wr) begin
            bm_mem[bm_addr] <= '0;
        end else if (cmd.bm_mark_wr) begin
            bm_mem[bm_addr] <= bm_q | mark_mask;
        end
        bm_q <= bm_mem[bm_addr];
    end

    assign out_valid          = out_valid_reg;
    assign out_slot           = o_slot_reg;
    assign out_status         = o_status_reg;
    assign out_capture_header = o_cap_reg;
    assign out_write_offset   = o_wo_reg;
    assign out_data_len       = o_dl_reg;
    assign out_expired_count  = o_ec_reg;

endmodule

// ----- rtl/ifrt_ctrl.sv -----
// Controller: sequences lookup, allocation, bitmap marking, checks and ticks.
module ifrt_ctrl import ifrt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ifrt_sts_t sts,
    output ifrt_cmd_t cmd
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_CHECK   = 16'b0000_0000_0000_0010,
        S_LK_RD   = 16'b0000_0000_0000_0100,
        S_LK_CMP  = 16'b0000_0000_0000_1000,
        S_ALLOC   = 16'b0000_0000_0001_0000,
        S_CLR     = 16'b0000_0000_0010_0000,
        S_MK_RD   = 16'b0000_0000_0100_0000,
        S_MK_WR   = 16'b0000_0000_1000_0000,
        S_LEN     = 16'b0000_0001_0000_0000,
        S_LEN_Q   = 16'b0000_0010_0000_0000,
        S_CK_INIT = 16'b0000_0100_0000_0000,
        S_CK_RD   = 16'b0000_1000_0000_0000,
        S_CK_CMP  = 16'b0001_0000_0000_0000,
        S_TK_RD   = 16'b0010_0000_0000_0000,
        S_TK_CMP  = 16'b0100_0000_0000_0000,
        S_EMIT    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        cmd        = '0;
        cmd.kind   = ST_PENDING;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.idx_clr = 1'b1;
                if (sts.is_tick) begin
                    cmd.time_inc = 1'b1;
                    state_next   = S_TK_RD;
                end else if (sts.malformed) begin
                    cmd.kind_set = 1'b1;
                    cmd.kind     = ST_MALFORMED;
                    state_next   = S_EMIT;
                end else begin
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD: state_next = S_LK_CMP;
            S_LK_CMP: begin
                cmd.rec_free = 1'b1;
                if (sts.match) begin
                    cmd.rec_hit = 1'b1;
                    cmd.w_first = 1'b1;
                    state_next  = sts.nblk_zero ? S_LEN : S_MK_RD;
                end else if (!sts.idx_last) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LK_RD;
                end else if (sts.free_found) begin
                    state_next = S_ALLOC;
                end else begin
                    cmd.kind_set = 1'b1;
                    cmd.kind     = ST_FULL;
                    state_next   = S_EMIT;
                end
            end
            S_ALLOC: begin
                cmd.alloc  = 1'b1;
                cmd.w_clr  = 1'b1;
                state_next = S_CLR;
            end
            S_CLR: begin
                // wipe the new slot's bitmap row one word a cycle
                cmd.bm_zero_wr = 1'b1;
                if (sts.clr_last) begin
                    cmd.w_first = 1'b1;
                    state_next  = sts.nblk_zero ? S_LEN : S_MK_RD;
                end else begin
                    cmd.w_inc = 1'b1;
                end
            end
            S_MK_RD: state_next = S_MK_WR;
            S_MK_WR: begin
                cmd.bm_mark_wr = 1'b1;
                if (sts.mk_last) begin
                    state_next = S_LEN;
                end else begin
                    cmd.w_inc  = 1'b1;
                    state_next = S_MK_RD;
                end
            end
            S_LEN: begin
                cmd.len_wr = sts.is_last;
                state_next = S_LEN_Q;
            end
            S_LEN_Q: begin
                cmd.len_latch = 1'b1;
                state_next    = S_CK_INIT;
            end
            S_CK_INIT: begin
                cmd.kind_set = 1'b1;
                if (!sts.known) begin
                    cmd.kind   = ST_PENDING;
                    state_next = S_EMIT;
                end else if (sts.cnt_zero) begin
                    cmd.kind      = ST_COMPLETE;
                    cmd.slot_free = 1'b1;
                    state_next    = S_EMIT;
                end else begin
                    cmd.kind_set = 1'b0;
                    cmd.w_clr    = 1'b1;
                    state_next   = S_CK_RD;
                end
            end
            S_CK_RD: state_next = S_CK_CMP;
            S_CK_CMP: begin
                if (!sts.ck_ok) begin
                    cmd.kind_set = 1'b1;
                    cmd.kind     = ST_PENDING;
                    state_next   = S_EMIT;
                end else if (sts.ck_last) begin
                    cmd.kind_set  = 1'b1;
                    cmd.kind      = ST_COMPLETE;
                    cmd.slot_free = 1'b1;
                    state_next    = S_EMIT;
                end else begin
                    cmd.w_inc  = 1'b1;
                    state_next = S_CK_RD;
                end
            end
            S_TK_RD: state_next = S_TK_CMP;
            S_TK_CMP: begin
                cmd.tick_check = 1'b1;
                if (sts.idx_last) begin
                    cmd.kind_set = 1'b1;
                    cmd.kind     = ST_TICK;
                    state_next   = S_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_TK_RD;
                end
            end
            S_EMIT: begin
                // hold until the result register is free
                if (!sts.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking stream testbench for the IP fragment reassembly tracker.
module tb import ifrt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 8;
    localparam int NBLK = 8192;

    typedef struct packed {
        logic        op;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] ident;
        logic [12:0] off;
        logic        mf;
        logic [15:0] plen;
    } frag_t;

    typedef struct packed {
        logic [2:0]  slot;
        status_t     status;
        logic        cap;
        logic [15:0] woff;
        logic [15:0] dlen;
        logic [3:0]  expired;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [119:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0] m_tuser;

    ip_fragment_reassembly_tracker i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // tracker mirror
    logic [7:0]  lifetime = 8'd30;
    logic [31:0] now_ticks = 32'd0;
    logic        live [NSLOT];
    logic [87:0] key_of [NSLOT];
    logic [31:0] expiry_of [NSLOT];
    logic [15:0] len_of [NSLOT];
    logic        len_known [NSLOT];
    logic [NBLK-1:0] blocks_of [NSLOT];

    frag_t    pending_frags[$];
    verdict_t expected_verdicts[$];
    int mismatches = 0;
    int n_done = 0, n_full = 0, n_bad = 0, n_expired = 0, n_sent = 0;
    logic hold_off = 1'b0;

    function automatic verdict_t track_item(frag_t f);
        verdict_t v;
        logic [87:0] k;
        logic [31:0] d, fin, nblk;
        int hit;
        v = '0;
        if (f.op) begin
            now_ticks = now_ticks + 32'd1;
            for (int s = 0; s < NSLOT; s++) begin
                d = expiry_of[s] - now_ticks;
                if (live[s] && (d == 0 || d[31])) begin
                    live[s] = 1'b0;
                    len_known[s] = 1'b0;
                    v.expired = v.expired + 4'd1;
                end
            end
            v.status = ST_TICK;
            return v;
        end
        k = {f.src, f.dst, f.proto, f.ident};
        fin = 32'(f.off) * 8 + 32'(f.plen);
        nblk = (32'(f.plen) + 7) / 8;
        if (fin > 65535 || 32'(f.off) + nblk > NBLK) begin
            v.status = ST_MALFORMED;
            return v;
        end
        hit = -1;
        for (int s = 0; s < NSLOT; s++)
            if (hit < 0 && live[s] && key_of[s] == k) hit = s;
        if (hit < 0) begin
            for (int s = 0; s < NSLOT; s++)
                if (hit < 0 && !live[s]) hit = s;
            if (hit < 0) begin
                v.status = ST_FULL;
                return v;
            end
            live[hit] = 1'b1;
            key_of[hit] = k;
            expiry_of[hit] = now_ticks + 32'(lifetime);
            len_of[hit] = '0;
            len_known[hit] = 1'b0;
            blocks_of[hit] = '0;
        end
        for (int b = 0; b < nblk; b++) blocks_of[hit][f.off + b] = 1'b1;
        if (!f.mf) begin
            len_of[hit] = fin[15:0];
            len_known[hit] = 1'b1;
        end
        v.slot = hit[2:0];
        v.status = ST_PENDING;
        v.cap = (f.off == 0);
        v.woff = 16'(32'(f.off) * 8);
        if (len_known[hit]) begin
            logic ok;
            ok = 1'b1;
            for (int b = 0; b < (int'(len_of[hit]) + 7) / 8; b++)
                if (!blocks_of[hit][b]) ok = 1'b0;
            if (ok) begin
                v.status = ST_COMPLETE;
                v.dlen = len_of[hit];
                live[hit] = 1'b0;
                len_known[hit] = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: predict at acceptance so ticks and config order stay exact
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(track_item(pending_frags.pop_front()));
                n_sent <= n_sent + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0 || hold_off || pending_frags.size() == 0
                    || (s_tvalid && s_tready && pending_frags.size() == 0)) begin
                    s_tvalid <= 1'b0;
                    if (tx_gap > 0) tx_gap <= tx_gap - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, pending_frags[0].plen, pending_frags[0].mf,
                                pending_frags[0].off, pending_frags[0].ident,
                                pending_frags[0].proto, pending_frags[0].dst,
                                pending_frags[0].src};
                    s_tuser <= pending_frags[0].op;
                    tx_gap <= gap_len();
                end
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h/%0d", m_tdata, m_tuser);
                end else begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if ({e.slot, e.cap, e.woff, e.dlen, e.expired} !==
                        {m_tdata[2:0], m_tdata[3], m_tdata[19:4], m_tdata[35:20],
                         m_tdata[39:36]} || m_tuser !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d slot=%0d cap=%0d wo=%0d dl=%0d",
                                e.status, e.slot, e.cap, e.woff, e.dlen,
                                " ex=%0d; got st=%0d slot=%0d cap=%0d wo=%0d dl=%0d ex=%0d",
                                e.expired, m_tuser, m_tdata[2:0], m_tdata[3],
                                m_tdata[19:4], m_tdata[35:20], m_tdata[39:36]);
                    end
                    case (e.status)
                        ST_COMPLETE: n_done++;
                        ST_FULL: n_full++;
                        ST_MALFORMED: n_bad++;
                        default: n_expired += e.expired;
                    endcase
                end
            end
            if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
            end
        end
    end

    // stimulus helpers
    function automatic frag_t tick_item();
        frag_t f;
        f = '0;
        f.op = 1'b1;
        f.src = $urandom();
        f.dst = $urandom();
        f.ident = 16'($urandom());
        return f;
    endfunction

    function automatic frag_t frag(logic [31:0] s, logic [31:0] d, logic [7:0] p,
                                   logic [15:0] id, logic [12:0] o, logic m,
                                   logic [15:0] l);
        frag_t f;
        f.op = 1'b0; f.src = s; f.dst = d; f.proto = p; f.ident = id;
        f.off = o; f.mf = m; f.plen = l;
        return f;
    endfunction

    // split one datagram into shuffled fragments, sometimes with a hole or a repeat
    task automatic queue_datagram(int pool);
        logic [31:0] s, d;
        logic [7:0] p;
        logic [15:0] id;
        int nb, pos, cut, n;
        frag_t parts[$];
        s = (pool > 0) ? 32'($urandom_range(0, pool)) : $urandom();
        d = (pool > 0) ? 32'hffff_fff0 : $urandom();
        p = 8'($urandom()); id = 16'($urandom());
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
        pos = 0;
        do begin
            n = $urandom_range(1, 12);
            if (pos + n > nb) n = nb - pos;
            if (pos + n == nb) begin
                cut = n * 8 - $urandom_range(0, 7);
                if (cut < 0) cut = 0;
                if (pos * 8 + cut > 65535) cut = 65535 - pos * 8;
                parts.push_back(frag(s, d, p, id, 13'(pos), 1'b0, 16'(cut)));
            end else
                parts.push_back(frag(s, d, p, id, 13'(pos), 1'b1, 16'(n * 8)));
            pos += n;
        end while (pos < nb);
        if ($urandom_range(0, 5) == 0 && parts.size() > 1)
            parts.delete($urandom_range(0, parts.size() - 1));
        if ($urandom_range(0, 5) == 0) parts.push_back(parts[0]);
        parts.shuffle();
        foreach (parts[i]) pending_frags.push_back(parts[i]);
    endtask

    task automatic drain();
        while (pending_frags.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic set_lifetime(logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lifetime = v;
    endtask

    initial begin
        logic [7:0] lifetimes [4];
        frag_t f;
        int r;
        bit paused;
        paused = 1'b0;
        for (int s = 0; s < NSLOT; s++) begin
            live[s] = 1'b0;
            len_known[s] = 1'b0;
        end
        lifetimes = '{8'd1, 8'd255, 8'd4, 8'd30};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, full table, malformed, empty last, expiry
        pending_frags.push_back(frag('1, '1, '1, '1, 13'd0, 1'b0, 16'd0));
        pending_frags.push_back(frag(32'd0, 32'd0, 8'd0, 16'd0, 13'd8191, 1'b0, 16'd8));
        pending_frags.push_back(frag(32'd0, 32'd0, 8'd0, 16'd0, 13'd0, 1'b1, 16'hffff));
        pending_frags.push_back(frag(32'd0, 32'd0, 8'd0, 16'd0, 13'd0, 1'b0, 16'd65535));
        pending_frags.push_back(frag(32'd0, 32'd0, 8'd0, 16'd0, 13'd8191, 1'b1, 16'd7));
        for (int i = 0; i < 9; i++)
            pending_frags.push_back(frag(32'(i), 32'h5555_aaaa, 8'h11, 16'h8000, 13'd1,
                                         1'b1, 16'd8));
        pending_frags.push_back(frag(32'd3, 32'h5555_aaaa, 8'h11, 16'h8000, 13'd2, 1'b0,
                                     16'd0));
        pending_frags.push_back(frag(32'd3, 32'h5555_aaaa, 8'h11, 16'h8000, 13'd2, 1'b0,
                                     16'd5));
        pending_frags.push_back(frag(32'd3, 32'h5555_aaaa, 8'h11, 16'h8000, 13'd0, 1'b1,
                                     16'd8));
        for (int i = 0; i < 31; i++) pending_frags.push_back(tick_item());
        pending_frags.push_back(frag(32'd1, 32'd2, 8'd3, 16'd4, 13'd4, 1'b0, 16'd1));
        pending_frags.push_back(tick_item());
        drain();

        foreach (lifetimes[k]) begin
            set_lifetime(lifetimes[k]);
            for (int n = 0; n < 340; ) begin
                r = $urandom_range(0, 99);
                if (r < 70) queue_datagram((r < 35) ? 3 : 0);
                else if (r < 85) pending_frags.push_back(tick_item());
                else begin
                    f = frag($urandom(), $urandom(), 8'($urandom()), 16'($urandom()),
                             13'($urandom()), 1'($urandom()), 16'($urandom()));
                    if ($urandom_range(0, 1) == 0) f.plen = 16'($urandom_range(0, 64));
                    pending_frags.push_back(f);
                end
                if (pending_frags.size() > 40) begin
                    n += pending_frags.size();
                    while (pending_frags.size() > 0) @(posedge aclk);
                end
                if (k == 1 && n >= 150 && !paused) begin
                    // pause the sender until every beat has come back
                    hold_off = 1'b1;
                    while (s_tvalid || expected_verdicts.size() > 0) @(posedge aclk);
                    hold_off = 1'b0;
                    paused = 1'b1;
                end
            end
            drain();
        end

        $display("tb: %0d items, %0d completed, %0d table-full drops,", n_sent, n_done,
                 n_full, " %0d malformed, %0d expired", n_bad, n_expired);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end
endmodule
